[design/fdep_pkg.sv]
// fdep_pkg: shared types, constants and helpers of the FAT directory entry parser.
// Used by fdep_lfn_store, fdep_seq and fat_directory_entry_parser_top; no dependencies.

package fdep_pkg;

	localparam int MAX_SLOTS      = 20;
	localparam int CHARS_PER_SLOT = 13;
	localparam int CHUNK_BYTES    = 8;
	localparam int ROW_W          = CHARS_PER_SLOT * 16;
	localparam int ROW_AW         = $clog2(MAX_SLOTS);
	localparam int CB_W           = $clog2(CHUNK_BYTES + 1);

	localparam logic [7:0] ATTR_LFN    = 8'h0F;
	localparam logic [7:0] MARK_DEL    = 8'hE5;
	localparam logic [7:0] MARK_END    = 8'h00;
	localparam logic [7:0] ATTR_VOLUME = 8'h08;
	localparam logic [7:0] ATTR_DIR    = 8'h10;
	localparam logic [7:0] SEQ_MASK    = 8'h3F;
	localparam logic [7:0] SEQ_FIRST   = 8'h40;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_DOT    = 8'h2E;
	localparam logic [7:0] CHAR_QMARK  = 8'h3F;
	localparam logic [15:0] CHAR_PAD   = 16'hFFFF;
	localparam logic [15:0] CHAR_NUL   = 16'h0000;

	// register indexes of the configuration port
	localparam logic CFG_ROOT_CLU     = 1'b0;
	localparam logic CFG_RESUME_INDEX = 1'b1;

	localparam logic KIND_NAME = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef logic [255:0] entry_t;
	typedef logic [ROW_W-1:0] row_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLASS,
		ST_SUM,
		ST_LEN,
		ST_EMIT,
		ST_PUSH
	} state_t;

	typedef struct packed {
		logic        kind;
		logic [63:0] name_chunk;
		logic [3:0]  chunk_bytes;
		logic [8:0]  name_length;
		logic        is_directory;
		logic [31:0] start_cluster;
		logic [31:0] file_size;
		logic [31:0] entry_position;
		logic        last;
	} result_t;

	function automatic logic [7:0] entry_byte(input entry_t e, input logic [4:0] k);
		return e[k*8 +: 8];
	endfunction

	// byte offsets of the 13 UCS-2 characters inside a long-name slot
	function automatic logic [4:0] slot_off(input int x);
		logic [4:0] o;
		unique case (x)
			0: o = 5'd1;   1: o = 5'd3;   2: o = 5'd5;   3: o = 5'd7;
			4: o = 5'd9;   5: o = 5'd14;  6: o = 5'd16;  7: o = 5'd18;
			8: o = 5'd20;  9: o = 5'd22;  10: o = 5'd24; 11: o = 5'd28;
			default: o = 5'd30;
		endcase
		return o;
	endfunction

	function automatic row_t slot_chars(input entry_t e);
		row_t r;
		for (int x = 0; x < CHARS_PER_SLOT; x++) begin
			r[x*16 +: 16] = e[32'(slot_off(x))*8 +: 16];
		end
		return r;
	endfunction

endpackage

[design/fdep_lfn_store.sv]
// fdep_lfn_store: long-name slot store, one 13-character row per slot, registered read.
// Depends on fdep_pkg. Per-row valid bits drive rd_vld low for unwritten rows.

module fdep_lfn_store (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clr,
	input  logic                     wr_en,
	input  logic [fdep_pkg::ROW_AW-1:0] wr_row,
	input  fdep_pkg::row_t           wr_data,
	input  logic [fdep_pkg::ROW_AW-1:0] rd_row,
	output fdep_pkg::row_t           rd_data,
	output logic                     rd_vld
);

	fdep_pkg::row_t mem [fdep_pkg::MAX_SLOTS];
	logic [fdep_pkg::MAX_SLOTS-1:0] vld_q;
	fdep_pkg::row_t rd_data_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row] <= wr_data;
		end
		rd_data_q <= mem[rd_row];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			vld_q <= (clr ? '0 : vld_q) |
				((wr_en ? {{(fdep_pkg::MAX_SLOTS-1){1'b0}}, 1'b1} : '0) << wr_row);
			rd_vld_q <= vld_q[rd_row];
		end
	end

	assign rd_data = rd_data_q;
	assign rd_vld  = rd_vld_q;

endmodule

[design/fdep_seq.sv]
// fdep_seq: entry classifier and name sequencer; one character per cycle, held by
// row fetches and a full output, through a shared character source (short name or
// slot store), serial checksum. Depends on fdep_pkg and fdep_lfn_store.

module fdep_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  fdep_pkg::entry_t    entry,
	input  logic                sod,
	input  logic [27:0]         root_clu,
	input  logic [31:0]         resume_index,
	input  logic                out_free,
	output logic                busy,
	output logic                push,
	output fdep_pkg::result_t   res
);

	fdep_pkg::state_t state_q, state_d;

	fdep_pkg::entry_t e_q;
	logic sod_q;
	logic [31:0] pos_q, pos_d;
	logic [4:0]  slots_q, slots_d;
	logic [7:0]  chk_q, chk_d;
	logic        ended_q, ended_d;
	logic [7:0]  sum_q, sum_d;
	logic [3:0]  k_q, k_d;
	logic        long_q, long_d;
	logic [8:0]  lim_q, lim_d;
	logic [8:0]  j_q, j_d;
	logic [fdep_pkg::ROW_AW-1:0] lrow_q, lrow_d;
	logic [3:0]  lcol_q, lcol_d;
	logic        rdv_q, rdv_d;
	logic [3:0]  sp_q, sp_d;
	logic [8:0]  len_q, len_d;
	logic [8:0]  emit_q, emit_d;
	logic [63:0] chunk_q, chunk_d;
	logic [fdep_pkg::CB_W-1:0] cb_q, cb_d;

	logic st_clr, st_wr;
	logic [fdep_pkg::ROW_AW-1:0] st_row, rd_row;
	fdep_pkg::row_t rd_data;
	logic rd_vld;

	logic [7:0] b0, attr;
	logic [5:0] num;
	logic [31:0] pos_eff, pos_inc;
	logic [4:0] slots_eff;
	logic ended_eff;
	logic [7:0] sum_nx;
	logic src_en, src_rst, ch_v, ch_end, row_adv;
	logic [7:0] ch;
	logic [15:0] lc;
	logic [7:0] sb;
	logic [31:0] cluster;

	assign rd_row = (lrow_q > fdep_pkg::ROW_AW'(fdep_pkg::MAX_SLOTS - 1)) ?
		fdep_pkg::ROW_AW'(fdep_pkg::MAX_SLOTS - 1) : lrow_q;

	fdep_lfn_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (st_clr),
		.wr_en   (st_wr),
		.wr_row  (st_row),
		.wr_data (fdep_pkg::slot_chars(e_q)),
		.rd_row  (rd_row),
		.rd_data (rd_data),
		.rd_vld  (rd_vld)
	);

	assign b0        = fdep_pkg::entry_byte(e_q, 5'd0);
	assign attr      = fdep_pkg::entry_byte(e_q, 5'd11);
	assign num       = b0[5:0] & fdep_pkg::SEQ_MASK[5:0];
	assign pos_eff   = sod_q ? '0 : pos_q;
	assign pos_inc   = pos_eff + 32'd1;
	assign slots_eff = sod_q ? '0 : slots_q;
	assign ended_eff = ended_q && !sod_q;
	assign sum_nx    = {sum_q[0], sum_q[7:1]} + fdep_pkg::entry_byte(e_q, {1'b0, k_q});
	assign st_row    = fdep_pkg::ROW_AW'(num - 6'd1);
	assign cluster   = {fdep_pkg::entry_byte(e_q, 5'd21), fdep_pkg::entry_byte(e_q, 5'd20),
		fdep_pkg::entry_byte(e_q, 5'd27), fdep_pkg::entry_byte(e_q, 5'd26)};

	// character source: one step per cycle, short name or slot store
	always_comb begin
		ch_v    = 1'b0;
		ch_end  = 1'b0;
		ch      = '0;
		row_adv = 1'b0;
		lc      = rd_vld ? rd_data[lcol_q*16 +: 16] : fdep_pkg::CHAR_PAD;
		sb      = '0;
		if (src_en) begin
			if (long_q) begin
				if (j_q == lim_q) begin
					ch_end = 1'b1;
				end else if (rdv_q) begin
					if (lc == fdep_pkg::CHAR_NUL || lc == fdep_pkg::CHAR_PAD) begin
						ch_end = 1'b1;
					end else begin
						ch_v    = 1'b1;
						ch      = (lc < 16'h0080) ? lc[7:0] : fdep_pkg::CHAR_QMARK;
						row_adv = (lcol_q == 4'(fdep_pkg::CHARS_PER_SLOT - 1));
					end
				end
			end else begin
				if (sp_q < 4'd8) begin
					sb = fdep_pkg::entry_byte(e_q, {1'b0, sp_q});
					ch_v = (sb != fdep_pkg::CHAR_SPACE);
					ch   = sb;
				end else if (sp_q == 4'd8) begin
					sb = fdep_pkg::entry_byte(e_q, 5'd8);
					ch_v   = (sb != fdep_pkg::CHAR_SPACE);
					ch_end = !ch_v;
					ch     = fdep_pkg::CHAR_DOT;
				end else if (sp_q < 4'd12) begin
					sb = fdep_pkg::entry_byte(e_q, {1'b0, sp_q - 4'd1});
					ch_v   = (sb != fdep_pkg::CHAR_SPACE);
					ch_end = !ch_v;
					ch     = sb;
				end else begin
					ch_end = 1'b1;
				end
			end
		end
	end

	always_comb begin
		state_d = state_q;
		pos_d   = pos_q;
		slots_d = slots_q;
		chk_d   = chk_q;
		ended_d = ended_q;
		sum_d   = sum_q;
		k_d     = k_q;
		long_d  = long_q;
		lim_d   = lim_q;
		len_d   = len_q;
		emit_d  = emit_q;
		chunk_d = chunk_q;
		cb_d    = cb_q;
		st_clr  = 1'b0;
		st_wr   = 1'b0;
		src_en  = 1'b0;
		src_rst = 1'b0;
		push    = 1'b0;
		res     = '0;
		unique case (state_q)
			fdep_pkg::ST_IDLE: begin
				if (start) begin
					state_d = fdep_pkg::ST_CLASS;
				end
			end
			fdep_pkg::ST_CLASS: begin
				pos_d   = pos_eff;
				slots_d = slots_eff;
				chk_d   = sod_q ? '0 : chk_q;
				ended_d = ended_eff;
				state_d = fdep_pkg::ST_IDLE;
				if (ended_eff) begin
					state_d = fdep_pkg::ST_IDLE;
				end else if (b0 == fdep_pkg::MARK_END) begin
					ended_d = 1'b1;
					len_d   = '0;
					state_d = fdep_pkg::ST_PUSH;
				end else if (b0 == fdep_pkg::MARK_DEL) begin
					slots_d = '0;
					pos_d   = pos_inc;
				end else if (attr == fdep_pkg::ATTR_LFN) begin
					if ((b0 & fdep_pkg::SEQ_FIRST) != '0) begin
						slots_d = (num > 6'(fdep_pkg::MAX_SLOTS)) ?
							5'(fdep_pkg::MAX_SLOTS) : num[4:0];
						chk_d  = fdep_pkg::entry_byte(e_q, 5'd13);
						st_clr = 1'b1;
					end
					st_wr = (num >= 6'd1) && (num <= 6'(fdep_pkg::MAX_SLOTS));
					pos_d = pos_inc;
				end else if ((attr & fdep_pkg::ATTR_VOLUME) != '0) begin
					slots_d = '0;
					pos_d   = pos_inc;
				end else begin
					pos_d   = pos_inc;
					slots_d = '0;
					if (pos_inc > resume_index) begin
						lim_d = 9'(slots_eff) * 9'(fdep_pkg::CHARS_PER_SLOT);
						sum_d = '0;
						k_d   = '0;
						len_d = '0;
						if (slots_eff != '0) begin
							state_d = fdep_pkg::ST_SUM;
						end else begin
							long_d  = 1'b0;
							src_rst = 1'b1;
							state_d = fdep_pkg::ST_LEN;
						end
					end
				end
			end
			fdep_pkg::ST_SUM: begin
				sum_d = sum_nx;
				k_d   = k_q + 4'd1;
				if (k_q == 4'd10) begin
					long_d  = (sum_nx == chk_q);
					src_rst = 1'b1;
					state_d = fdep_pkg::ST_LEN;
				end
			end
			fdep_pkg::ST_LEN: begin
				src_en = 1'b1;
				if (ch_v) begin
					len_d = len_q + 9'd1;
				end
				if (ch_end) begin
					src_rst = 1'b1;
					emit_d  = '0;
					cb_d    = '0;
					chunk_d = '0;
					state_d = (len_q == '0) ? fdep_pkg::ST_IDLE : fdep_pkg::ST_EMIT;
				end
			end
			fdep_pkg::ST_EMIT: begin
				src_en = 1'b1;
				if (ch_v) begin
					chunk_d[cb_q*8 +: 8] = ch;
					cb_d   = cb_q + fdep_pkg::CB_W'(1);
					emit_d = emit_q + 9'd1;
					if (cb_q == fdep_pkg::CB_W'(fdep_pkg::CHUNK_BYTES - 1) ||
					    emit_q + 9'd1 == len_q) begin
						state_d = fdep_pkg::ST_PUSH;
					end
				end
			end
			fdep_pkg::ST_PUSH: begin
				res.entry_position = pos_q;
				res.last           = (len_q == '0) || (emit_q == len_q);
				if (len_q == '0) begin
					res.kind = fdep_pkg::KIND_END;
				end else begin
					res.kind          = fdep_pkg::KIND_NAME;
					res.name_chunk    = chunk_q;
					res.chunk_bytes   = 4'(cb_q);
					res.name_length   = len_q;
					res.is_directory  = (attr & fdep_pkg::ATTR_DIR) != '0;
					res.start_cluster = (cluster == '0) ? {4'd0, root_clu} : cluster;
					res.file_size     = e_q[255:224];
				end
				if (out_free) begin
					push    = 1'b1;
					cb_d    = '0;
					chunk_d = '0;
					state_d = res.last ? fdep_pkg::ST_IDLE : fdep_pkg::ST_EMIT;
				end
			end
			default: state_d = fdep_pkg::ST_IDLE;
		endcase
	end

	// source position update
	always_comb begin
		j_d    = j_q;
		lrow_d = lrow_q;
		lcol_d = lcol_q;
		sp_d   = sp_q;
		rdv_d  = 1'b1;
		if (src_rst) begin
			j_d    = '0;
			lrow_d = '0;
			lcol_d = '0;
			sp_d   = '0;
			rdv_d  = 1'b0;
		end else if (src_en) begin
			if (long_q) begin
				if (ch_v) begin
					j_d = j_q + 9'd1;
					if (row_adv) begin
						lcol_d = '0;
						lrow_d = lrow_q + fdep_pkg::ROW_AW'(1);
						rdv_d  = 1'b0;
					end else begin
						lcol_d = lcol_q + 4'd1;
					end
				end
			end else if (!ch_end) begin
				sp_d = (sp_q < 4'd8 && !ch_v) ? 4'd8 : sp_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == fdep_pkg::ST_IDLE) begin
			e_q   <= entry;
			sod_q <= sod;
		end
		sum_q   <= sum_d;
		k_q     <= k_d;
		long_q  <= long_d;
		lim_q   <= lim_d;
		len_q   <= len_d;
		emit_q  <= emit_d;
		chunk_q <= chunk_d;
		cb_q    <= cb_d;
		j_q     <= j_d;
		lrow_q  <= lrow_d;
		lcol_q  <= lcol_d;
		sp_q    <= sp_d;
		rdv_q   <= rdv_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fdep_pkg::ST_IDLE;
			pos_q   <= '0;
			slots_q <= '0;
			chk_q   <= '0;
			ended_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
			slots_q <= slots_d;
			chk_q   <= chk_d;
			ended_q <= ended_d;
		end
	end

	assign busy = (state_q != fdep_pkg::ST_IDLE);

endmodule

[design/fat_directory_entry_parser_top.sv]
// fat_directory_entry_parser_top: top level of the FAT directory entry parser.
// Depends on fdep_pkg and fdep_seq (which holds fdep_lfn_store).
//
// Input channel (in_valid / in_stall): one raw 32-byte directory entry per transfer
// in entry_word0..3, plus start_of_directory. Output channel (out_valid / out_stall):
// name chunks of up to 8 bytes per transfer for visible entries, or one end result.
// Config: cfg_write with cfg_index/cfg_data sets the root cluster and the resume
// index; write only while idle.
// Timing: one entry at a time; in_stall is high from acceptance until the entry is
// done. Slots, deleted entries, labels and skipped entries end in the class state.
// A visible entry then runs a serial checksum (long names only), a length pass and
// a chunk pass with a push per chunk; the shared character source delivers one
// character per cycle, once for each pass, but waits on each slot row fetch.
// The longest name is a 260-character long name.
// Output: a result register; while out_stall holds it the sequencer waits.
// Reset: arst_n clears position, slot count, checksum, end flag and all slot valid
// bits (store reads as empty); the root cluster resets to 2, the resume index to 0.

module fat_directory_entry_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] entry_word0,
	input  logic [63:0] entry_word1,
	input  logic [63:0] entry_word2,
	input  logic [63:0] entry_word3,
	input  logic        start_of_directory,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [63:0] name_chunk,
	output logic [3:0]  chunk_bytes,
	output logic [8:0]  name_length,
	output logic        is_directory,
	output logic [31:0] start_cluster,
	output logic [31:0] file_size,
	output logic [31:0] entry_position,
	output logic        last,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	logic [27:0] root_clu_q;
	logic [31:0] resume_index_q;
	logic out_valid_q;
	fdep_pkg::result_t res_q, res;
	logic busy, push, out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = busy;

	fdep_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (in_valid),
		.entry        ({entry_word3, entry_word2, entry_word1, entry_word0}),
		.sod          (start_of_directory),
		.root_clu     (root_clu_q),
		.resume_index (resume_index_q),
		.out_free     (out_free),
		.busy         (busy),
		.push         (push),
		.res          (res)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_clu_q     <= 28'd2;
			resume_index_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				fdep_pkg::CFG_ROOT_CLU:     root_clu_q     <= cfg_data[27:0];
				fdep_pkg::CFG_RESUME_INDEX: resume_index_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = res_q.kind;
	assign name_chunk     = res_q.name_chunk;
	assign chunk_bytes    = res_q.chunk_bytes;
	assign name_length    = res_q.name_length;
	assign is_directory   = res_q.is_directory;
	assign start_cluster  = res_q.start_cluster;
	assign file_size      = res_q.file_size;
	assign entry_position = res_q.entry_position;
	assign last           = res_q.last;

	// an accepted entry makes the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("entry accepted but block not busy");

	// a result is only loaded into a free register
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result pushed over a waiting one");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == fdep_pkg::KIND_END) |-> last)
		else $error("end result without last");

	a_chunk_size: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == fdep_pkg::KIND_NAME) |->
		(chunk_bytes != 4'd0 && chunk_bytes <= 4'(fdep_pkg::CHUNK_BYTES) &&
		name_length != 9'd0))
		else $error("bad chunk size or name length");

endmodule
